// ===== rtl/core/b64sd_pkg.sv =====
// Package for the base64 stream decoder: types and constants shared by the
// front end, the queue and the back end, and the symbol and byte-packing
// helpers used by the front end. No dependencies.
`default_nettype none

package b64sd_pkg;

  // Decoded byte counter width (saturating) and the width shown at the port
  localparam int COUNT_BITS  = 24;
  localparam int OUT_COUNT_W = 24;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Special characters
  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // Value forced into the third byte by an invalid fourth character
  localparam logic [7:0] BYTE_BAD = 8'hFF;

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_GROUP,
    PH_AFTER_CR,
    PH_IN_GROUP,
    PH_DONE
  } b64sd_phase_e;

  // One queued command: up to three bytes, or none for an end-only marker
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            eom;
  } b64sd_cmd_t;

  // Returns {invalid, symbol}; an invalid character maps to symbol 63
  function automatic logic [6:0] sym_lookup(logic [7:0] c);
    logic [7:0] d;
    logic       bad;
    d   = 8'h3F;
    bad = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d   = c - 8'h41;
      bad = 1'b0;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d   = c - 8'h47;
      bad = 1'b0;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d   = c + 8'h04;
      bad = 1'b0;
    end else if (c == 8'h2B) begin
      d   = 8'h3E;
      bad = 1'b0;
    end else if (c == 8'h2F) begin
      d   = 8'h3F;
      bad = 1'b0;
    end
    return {bad, d[5:0]};
  endfunction

  // Pack three symbols into three bytes; fourth is ORed into the third byte
  function automatic logic [2:0][7:0] pack_bytes(logic [5:0] h0, logic [5:0] h1,
                                                 logic [5:0] h2, logic [7:0] fourth);
    logic [2:0][7:0] b;
    b[0] = {h0, h1[5:4]};
    b[1] = {h1[3:0], h2[5:2]};
    b[2] = {h2[1:0], 6'b0} | fourth;
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64sd_if.sv =====
// Stream interfaces of the base64 stream decoder: character input and byte output.
// Depends on b64sd_pkg for the count width.
`default_nettype none

interface b64sd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface b64sd_byte_if;
  logic                               valid;
  logic                               ready;
  logic [7:0]                         data_byte;
  logic                               byte_valid;
  logic                               end_of_message;
  logic [b64sd_pkg::OUT_COUNT_W-1:0]  byte_count;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, output byte_count, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, input byte_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b64sd_front.sv =====
// Front end: accepts characters, tracks group and line-break phase, and
// turns each completed or closed group into one queued command.
// Depends on b64sd_pkg and b64sd_if.
`default_nettype none

module b64sd_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  b64sd_char_if.sink             char_i,
  input  wire                    cmd_full_i,
  output logic                   cmd_push_o,
  output b64sd_pkg::b64sd_cmd_t  cmd_o
);

  b64sd_pkg::b64sd_phase_e phase_q, phase_d;
  logic [1:0] pos_q, pos_d;
  logic [5:0] h0_q, h0_d, h1_q, h1_d, h2_q, h2_d;
  logic       pad_q, pad_d;

  logic       acc;
  logic [6:0] lk;
  logic [5:0] sym;
  logic       bad;
  logic       is_pad;
  logic       skip_cr;
  logic       skip_lf;

  assign char_i.ready = !cmd_full_i;
  assign acc     = char_i.valid && char_i.ready;
  assign lk      = b64sd_pkg::sym_lookup(char_i.char_code);
  assign sym     = lk[5:0];
  assign bad     = lk[6];
  assign is_pad  = (char_i.char_code == b64sd_pkg::CHAR_PAD);
  assign skip_cr = (phase_q == b64sd_pkg::PH_AFTER_GROUP) &&
                   (char_i.char_code == b64sd_pkg::CHAR_CR);
  assign skip_lf = (phase_q == b64sd_pkg::PH_AFTER_CR) &&
                   (char_i.char_code == b64sd_pkg::CHAR_LF);

  // Next state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    h2_d    = h2_q;
    pad_d   = pad_q;
    if (acc) begin
      case (phase_q)
        b64sd_pkg::PH_IN_GROUP: begin
          case (pos_q)
            2'd1: begin
              h1_d  = sym;
              pos_d = 2'd2;
            end
            2'd2: begin
              if (is_pad) begin
                pad_d = 1'b1;
              end else begin
                h2_d = sym;
              end
              pos_d = 2'd3;
            end
            default: begin
              // group complete: clear and wait for a possible line break
              phase_d = b64sd_pkg::PH_AFTER_GROUP;
              pos_d   = 2'd0;
              h0_d    = '0;
              h1_d    = '0;
              h2_d    = '0;
              pad_d   = 1'b0;
            end
          endcase
        end
        b64sd_pkg::PH_START, b64sd_pkg::PH_AFTER_GROUP, b64sd_pkg::PH_AFTER_CR: begin
          if (skip_cr) begin
            phase_d = b64sd_pkg::PH_AFTER_CR;
          end else if (skip_lf) begin
            phase_d = b64sd_pkg::PH_START;
          end else if (char_i.char_code == b64sd_pkg::CHAR_NUL) begin
            phase_d = b64sd_pkg::PH_DONE;
          end else begin
            h0_d    = sym;
            pos_d   = 2'd1;
            phase_d = b64sd_pkg::PH_IN_GROUP;
          end
        end
        default: begin
        end
      endcase
      if (char_i.last) begin
        phase_d = b64sd_pkg::PH_START;
        pos_d   = 2'd0;
        h0_d    = '0;
        h1_d    = '0;
        h2_d    = '0;
        pad_d   = 1'b0;
      end
    end
  end

  // Command for this transaction
  always_comb begin
    cmd_o.bytes  = b64sd_pkg::pack_bytes(h0_q, h1_q, h2_q, 8'h00);
    cmd_o.nbytes = 2'd0;
    cmd_o.eom    = char_i.last;
    case (phase_q)
      b64sd_pkg::PH_IN_GROUP: begin
        case (pos_q)
          2'd1: begin
            if (char_i.last) begin
              cmd_o.bytes  = b64sd_pkg::pack_bytes(h0_q, sym, 6'd0, 8'h00);
              cmd_o.nbytes = 2'd1;
            end
          end
          2'd2: begin
            if (char_i.last) begin
              // closing on the third character: a pad leaves one byte, else two
              cmd_o.bytes  = b64sd_pkg::pack_bytes(h0_q, h1_q, is_pad ? h2_q : sym, 8'h00);
              cmd_o.nbytes = is_pad ? 2'd1 : 2'd2;
            end
          end
          default: begin
            if (pad_q) begin
              cmd_o.nbytes = 2'd1;
            end else if (is_pad) begin
              cmd_o.nbytes = 2'd2;
            end else begin
              cmd_o.bytes  = b64sd_pkg::pack_bytes(h0_q, h1_q, h2_q,
                                                   bad ? b64sd_pkg::BYTE_BAD : {2'b00, sym});
              cmd_o.nbytes = 2'd3;
            end
          end
        endcase
      end
      b64sd_pkg::PH_START, b64sd_pkg::PH_AFTER_GROUP, b64sd_pkg::PH_AFTER_CR: begin
        // a lone first character closes as one byte with the second forced to 63
        if (char_i.last && !skip_cr && !skip_lf &&
            char_i.char_code != b64sd_pkg::CHAR_NUL) begin
          cmd_o.bytes  = b64sd_pkg::pack_bytes(sym, 6'h3F, 6'd0, 8'h00);
          cmd_o.nbytes = 2'd1;
        end
      end
      default: begin
      end
    endcase
    cmd_push_o = acc && ((cmd_o.nbytes != 2'd0) || char_i.last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64sd_pkg::PH_START;
      pos_q   <= 2'd0;
      h0_q    <= '0;
      h1_q    <= '0;
      h2_q    <= '0;
      pad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      h0_q    <= h0_d;
      h1_q    <= h1_d;
      h2_q    <= h2_d;
      pad_q   <= pad_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64sd_cmd_fifo.sv =====
// Short command queue between front and back end of the base64 decoder.
// Depends on b64sd_pkg for the command type and depth.
`default_nettype none

module b64sd_cmd_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire b64sd_pkg::b64sd_cmd_t push_data_i,
  output logic                   full_o,
  input  wire                    pop_i,
  output logic                   empty_o,
  output b64sd_pkg::b64sd_cmd_t  head_o
);

  localparam logic [b64sd_pkg::FIFO_PTR_W-1:0] LastPtr =
    b64sd_pkg::FIFO_PTR_W'(b64sd_pkg::FIFO_DEPTH - 1);
  localparam logic [b64sd_pkg::FIFO_CNT_W-1:0] FullCnt =
    b64sd_pkg::FIFO_CNT_W'(b64sd_pkg::FIFO_DEPTH);

  b64sd_pkg::b64sd_cmd_t entry_q [b64sd_pkg::FIFO_DEPTH];
  logic [b64sd_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [b64sd_pkg::FIFO_CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64sd_back.sv =====
// Back end: plays out each queued command one byte per cycle into the
// output register while it is not held off, and keeps the saturating byte
// count of the message. Depends on b64sd_pkg and b64sd_if.
`default_nettype none

module b64sd_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    head_valid_i,
  input  wire b64sd_pkg::b64sd_cmd_t head_i,
  output logic                   pop_o,
  b64sd_byte_if.source           byte_o
);

  logic [b64sd_pkg::COUNT_BITS-1:0]  count_q;
  logic [b64sd_pkg::COUNT_BITS-1:0]  count_inc;
  logic [1:0]                        idx_q;
  logic [1:0]                        last_idx;
  logic                              has_byte;
  logic                              fin;
  logic                              step;
  logic [31:0]                       count_ext;

  logic                              ov_q;
  logic [7:0]                        data_q;
  logic                              bval_q;
  logic                              eom_q;
  logic [b64sd_pkg::OUT_COUNT_W-1:0] bcnt_q;

  assign has_byte  = (head_i.nbytes != 2'd0);
  assign last_idx  = has_byte ? 2'(head_i.nbytes - 2'd1) : 2'd0;
  assign fin       = (idx_q == last_idx);
  assign step      = head_valid_i && (!ov_q || byte_o.ready);
  assign pop_o     = step && fin;
  assign count_inc = (has_byte && count_q != '1) ? count_q + 1'b1 : count_q;
  assign count_ext = 32'(count_inc);

  assign byte_o.valid          = ov_q;
  assign byte_o.data_byte      = data_q;
  assign byte_o.byte_valid     = bval_q;
  assign byte_o.end_of_message = eom_q;
  assign byte_o.byte_count     = bcnt_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      data_q <= has_byte ? head_i.bytes[idx_q] : 8'h00;
      bval_q <= has_byte;
      eom_q  <= head_i.eom && fin;
      bcnt_q <= count_ext[b64sd_pkg::OUT_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      idx_q   <= 2'd0;
      count_q <= '0;
    end else begin
      if (step) begin
        ov_q  <= 1'b1;
        idx_q <= fin ? 2'd0 : idx_q + 2'd1;
        // restart the count once the message's final result is out
        count_q <= (head_i.eom && fin) ? '0 : count_inc;
      end else if (byte_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// Base64 stream decoder, top level: front end, command queue and back end.
// Depends on b64sd_pkg, b64sd_if, b64sd_front, b64sd_cmd_fifo and b64sd_back.
//
// Takes one base64 character per cycle and delivers decoded bytes one per
// cycle through a registered output. A group of four characters yields up to
// three bytes as a single command in a four-entry queue; the back end plays a
// command out one byte at a time and moves straight on to the next one, so
// sustained input is one character per cycle. Input stalls only when the queue
// is full, which happens when the output is held off. Every message ends with
// one result marked end_of_message, an end-only marker when the final
// character gives no byte; the count restarts after it.
`default_nettype none

module base64_stream_decoder_unit (
  input  wire           clk_i,
  input  wire           rst_ni,
  b64sd_char_if.sink    char_i,
  b64sd_byte_if.source  byte_o
);

  logic                  cmd_push;
  logic                  cmd_full;
  logic                  cmd_empty;
  logic                  cmd_pop;
  b64sd_pkg::b64sd_cmd_t cmd_in;
  b64sd_pkg::b64sd_cmd_t cmd_head;

  b64sd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (char_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  b64sd_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .empty_o     (cmd_empty),
    .head_o      (cmd_head)
  );

  b64sd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!cmd_empty),
    .head_i       (cmd_head),
    .pop_o        (cmd_pop),
    .byte_o       (byte_o)
  );

endmodule

`default_nettype wire
